@@ hdl/fat12ct_pkg.sv @@
`default_nettype none

package fat12ct_pkg;

  // Action codes carried by an input item
  localparam logic [2:0] ACT_LOAD_BYTE  = 3'd0;
  localparam logic [2:0] ACT_READ_BYTE  = 3'd1;
  localparam logic [2:0] ACT_GET_ENTRY  = 3'd2;
  localparam logic [2:0] ACT_SET_ENTRY  = 3'd3;
  localparam logic [2:0] ACT_FIND_FREE  = 3'd4;
  localparam logic [2:0] ACT_FREE_CHAIN = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FREE   = 2'd1;
  localparam logic [1:0] ST_CHAIN_CAP = 2'd2;

  // Link encoding
  localparam logic [11:0] END_MARK           = 12'hFF8;
  localparam logic [15:0] LINK_END           = 16'hFFFF;
  localparam logic [12:0] FIRST_DATA_CLUSTER = 13'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [11:0] cluster;
    logic [11:0] new_value;
    logic [12:0] byte_address;
    logic [7:0]  byte_in;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] link_value;
    logic [7:0]  byte_out;
    logic [12:0] freed_count;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BYTE,
    S_BYTE_CAP,
    S_CHECK,
    S_RD0,
    S_RD1,
    S_EVAL,
    S_WR0,
    S_WR1,
    S_DONE
  } fsm_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE,
    OP_BYTE,
    OP_BYTE_CAP,
    OP_RD_LO,
    OP_RD_HI,
    OP_EVAL,
    OP_WR_LO,
    OP_WR_HI,
    OP_FAIL,
    OP_CAP_OVF,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] in_action;
    logic [2:0] action;
    logic       search_done;
    logic       chain_end;
    logic       cap_hit;
    logic       entry_zero;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/fat12ct_ifs.sv @@
`default_nettype none

interface fat12ct_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [11:0] cluster;
  logic [11:0] new_value;
  logic [12:0] byte_address;
  logic [7:0]  byte_in;

  modport source (output valid, action, cluster, new_value, byte_address, byte_in,
                  input ready);
  modport sink (input valid, action, cluster, new_value, byte_address, byte_in,
                output ready);
endinterface

interface fat12ct_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] link_value;
  logic [7:0]  byte_out;
  logic [12:0] freed_count;

  modport source (output valid, status, link_value, byte_out, freed_count,
                  input ready);
  modport sink (input valid, status, link_value, byte_out, freed_count,
                output ready);
endinterface

interface fat12ct_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] highest_cluster;

  modport source (output valid, highest_cluster, input ready);
  modport sink (input valid, highest_cluster, output ready);
endinterface

`default_nettype wire

@@ hdl/fat12ct_ram.sv @@
`default_nettype none

module fat12ct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 6144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ hdl/fat12ct_ctrl.sv @@
`default_nettype none

module fat12ct_ctrl
  import fat12ct_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          priority if (stat.in_action == ACT_LOAD_BYTE || stat.in_action == ACT_READ_BYTE)
            state_next = S_BYTE;
          else if (stat.in_action == ACT_GET_ENTRY || stat.in_action == ACT_SET_ENTRY)
            state_next = S_RD0;
          else if (stat.in_action == ACT_FIND_FREE || stat.in_action == ACT_FREE_CHAIN)
            state_next = S_CHECK;
          else
            state_next = S_DONE;
        end
      end
      S_BYTE: begin
        state_next = (stat.action == ACT_READ_BYTE) ? S_BYTE_CAP : S_DONE;
      end
      S_BYTE_CAP: state_next = S_DONE;
      S_CHECK: begin
        if (stat.action == ACT_FIND_FREE) begin
          state_next = stat.search_done ? S_DONE : S_RD0;
        end else begin
          state_next = (stat.chain_end || stat.cap_hit) ? S_DONE : S_RD0;
        end
      end
      S_RD0: state_next = S_RD1;
      S_RD1: state_next = S_EVAL;
      S_EVAL: begin
        priority if (stat.action == ACT_GET_ENTRY)
          state_next = S_DONE;
        else if (stat.action == ACT_FIND_FREE)
          state_next = stat.entry_zero ? S_DONE : S_CHECK;
        else
          state_next = S_WR0;
      end
      S_WR0: state_next = S_WR1;
      S_WR1: begin
        state_next = (stat.action == ACT_FREE_CHAIN) ? S_CHECK : S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd.op = OP_NONE;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_TAKE;
        end
      end
      S_BYTE:     cmd.op = OP_BYTE;
      S_BYTE_CAP: cmd.op = OP_BYTE_CAP;
      S_CHECK: begin
        if (stat.action == ACT_FIND_FREE) begin
          if (stat.search_done) begin
            cmd.op = OP_FAIL;
          end
        end else if (!stat.chain_end && stat.cap_hit) begin
          cmd.op = OP_CAP_OVF;
        end
      end
      S_RD0:  cmd.op = OP_RD_LO;
      S_RD1:  cmd.op = OP_RD_HI;
      S_EVAL: cmd.op = OP_EVAL;
      S_WR0:  cmd.op = OP_WR_LO;
      S_WR1:  cmd.op = OP_WR_HI;
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op = OP_PUBLISH;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/fat12ct_dp.sv @@
`default_nettype none

module fat12ct_dp
  import fat12ct_pkg::*;
#(
  parameter int ENTRY_COUNT = 4096,
  parameter int TABLE_BYTES = 6144
) (
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        cfg_we,
  input  logic [11:0] cfg_value,
  output result_t     result,
  output logic        out_valid,
  input  logic        out_ready
);

  localparam int AddrW = $clog2(TABLE_BYTES);
  localparam logic [11:0] MaxCluster = 12'(ENTRY_COUNT - 1);
  localparam logic [12:0] CapCount = 13'(ENTRY_COUNT);

  item_t       held;
  result_t     res;
  logic [12:0] cur;
  logic [11:0] nxt;
  logic [7:0]  lo_byte;
  logic [7:0]  hi_byte;
  logic        lo_ok;
  logic        hi_ok;
  logic [11:0] highest_cluster;

  logic [12:0]      off;
  logic [12:0]      off_hi;
  logic             off_ok;
  logic             off_hi_ok;
  logic             byte_ok;
  logic [7:0]       hi_now;
  logic [11:0]      raw;
  logic [11:0]      top;
  logic [11:0]      wr_val;
  logic [7:0]       wr_lo;
  logic [7:0]       wr_hi;
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;

  // Entry c sits at byte offset c + c/2
  assign off       = {1'b0, cur[11:0]} + {2'b00, cur[11:1]};
  assign off_hi    = off + 13'd1;
  assign off_ok    = 32'(off) < TABLE_BYTES;
  assign off_hi_ok = 32'(off_hi) < TABLE_BYTES;
  assign byte_ok   = 32'(held.byte_address) < TABLE_BYTES;

  // Unpack the 12-bit entry from the little-endian word
  assign hi_now = hi_ok ? ram_rdata : 8'd0;
  assign raw    = cur[0] ? {hi_now, lo_byte[7:4]} : {hi_now[3:0], lo_byte};

  // Merge the new link (zero when freeing a chain) into the held word
  assign wr_val = (held.action == ACT_SET_ENTRY) ? held.new_value : 12'd0;
  assign wr_lo  = cur[0] ? {wr_val[3:0], lo_byte[3:0]} : wr_val[7:0];
  assign wr_hi  = cur[0] ? wr_val[11:4] : {hi_byte[7:4], wr_val[11:8]};

  assign top = (highest_cluster > MaxCluster) ? MaxCluster : highest_cluster;

  // Table port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = wr_lo;
    ram_addr  = off[AddrW-1:0];
    unique case (cmd.op)
      OP_BYTE: begin
        ram_addr  = held.byte_address[AddrW-1:0];
        ram_wdata = held.byte_in;
        ram_we    = (held.action == ACT_LOAD_BYTE) && byte_ok;
      end
      OP_RD_HI: ram_addr = off_hi[AddrW-1:0];
      OP_WR_LO: begin
        ram_we    = lo_ok;
        ram_wdata = wr_lo;
      end
      OP_WR_HI: begin
        ram_addr  = off_hi[AddrW-1:0];
        ram_we    = hi_ok;
        ram_wdata = wr_hi;
      end
      default: ram_addr = off[AddrW-1:0];
    endcase
  end

  fat12ct_ram #(
    .WIDTH(8),
    .DEPTH(TABLE_BYTES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Status back to the controller
  assign stat.in_action   = item.action;
  assign stat.action      = held.action;
  assign stat.search_done = cur > {1'b0, top};
  assign stat.chain_end   = (cur[11:0] == 12'd0) || (cur[11:0] >= END_MARK);
  assign stat.cap_hit     = res.freed_count >= CapCount;
  assign stat.entry_zero  = raw == 12'd0;
  assign stat.out_free    = !out_valid || out_ready;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      highest_cluster <= 12'hFFF;
    end else if (cfg_we) begin
      highest_cluster <= cfg_value;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_TAKE: begin
        held <= item;
        res  <= '0;
        cur  <= (item.action == ACT_FIND_FREE) ? FIRST_DATA_CLUSTER : {1'b0, item.cluster};
      end
      OP_BYTE_CAP: res.byte_out <= byte_ok ? ram_rdata : 8'd0;
      OP_RD_LO:    lo_ok <= off_ok;
      OP_RD_HI: begin
        lo_byte <= lo_ok ? ram_rdata : 8'd0;
        hi_ok   <= off_hi_ok;
      end
      OP_EVAL: begin
        hi_byte <= hi_now;
        nxt     <= raw;
        if (held.action == ACT_GET_ENTRY) begin
          res.link_value <= (raw >= END_MARK) ? LINK_END : {4'd0, raw};
        end else if (held.action == ACT_FIND_FREE) begin
          if (raw == 12'd0) begin
            res.status     <= ST_OK;
            res.link_value <= {3'd0, cur};
          end else begin
            cur <= cur + 13'd1;
          end
        end
      end
      OP_WR_HI: begin
        if (held.action == ACT_FREE_CHAIN) begin
          res.freed_count <= res.freed_count + 13'd1;
          cur             <= {1'b0, nxt};
        end
      end
      OP_FAIL: begin
        res.status     <= ST_NO_FREE;
        res.link_value <= LINK_END;
      end
      OP_CAP_OVF: res.status <= ST_CHAIN_CAP;
      default: ;
    endcase
  end

  // Output register: hold the item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_PUBLISH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PUBLISH) begin
      result <= res;
    end
  end

  a_freed_capped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result.freed_count <= CapCount))
    else $error("freed count beyond entry count");

  a_write_in_table: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (32'(ram_addr) < TABLE_BYTES))
    else $error("table write outside the table");

  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_PUBLISH) |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

  a_find_bounded: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_RD_LO && held.action == ACT_FIND_FREE) |-> (cur <= {1'b0, top}))
    else $error("free search read past the limit");

endmodule

`default_nettype wire

@@ hdl/fat12_cluster_table_engine_unit.sv @@
`default_nettype none

// Channel   Dir  Handshake     Payload
// items     in   valid/ready   action, cluster, new_value, byte_address, byte_in
// results   out  valid/ready   status, link_value, byte_out, freed_count
// cfg       in   valid/ready   highest_cluster (ready is always high)
//
// One item at a time; all work goes through the single-port table RAM.
// Set entry makes two byte reads and two byte writes per entry; find free reads
// each entry it examines, and free chain reads and clears each entry in turn.
// A finished result waits in the output register while the next item enters;
// a new result leaves the final state only once that register is free.
// Reset clears control and sets highest_cluster to 4095; the table is not cleared.

module fat12_cluster_table_engine_unit
  import fat12ct_pkg::*;
#(
  parameter int ENTRY_COUNT = 4096,
  parameter int TABLE_BYTES = 6144
) (
  input logic              clk,
  input logic              rst,
  fat12ct_item_if.sink     items,
  fat12ct_result_if.source results,
  fat12ct_cfg_if.sink      cfg
);

  item_t    item;
  result_t  result;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     out_valid;
  logic     in_ready;

  // Gather the input item
  assign item.action       = items.action;
  assign item.cluster      = items.cluster;
  assign item.new_value    = items.new_value;
  assign item.byte_address = items.byte_address;
  assign item.byte_in      = items.byte_in;
  assign items.ready       = in_ready;

  // Spread the result item
  assign results.valid       = out_valid;
  assign results.status      = result.status;
  assign results.link_value  = result.link_value;
  assign results.byte_out    = result.byte_out;
  assign results.freed_count = result.freed_count;

  assign cfg.ready = 1'b1;

  fat12ct_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(items.valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  fat12ct_dp #(
    .ENTRY_COUNT(ENTRY_COUNT),
    .TABLE_BYTES(TABLE_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cmd      (cmd),
    .stat     (stat),
    .cfg_we   (cfg.valid),
    .cfg_value(cfg.highest_cluster),
    .result   (result),
    .out_valid(out_valid),
    .out_ready(results.ready)
  );

endmodule

`default_nettype wire
